/* design/ordered_key_value_map_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ordered key-value map
// Concurrent assertion wrappers that can be compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_VALUE_MAP_ASSERT_SVH
`define ORDERED_KEY_VALUE_MAP_ASSERT_SVH

`ifndef ASSERT_OFF
// Property checked on every rising edge while reset is released.
`define OKVM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered_key_value_map assertion failed");
// Property checked on every rising edge, also during reset.
`define OKVM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ordered_key_value_map assertion failed");
`else
`define OKVM_ASSERT(label, clk, rst_n, prop)
`define OKVM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* design/okvm_pkg.sv */
// ----------------------------------------------------------------------------
// okvm_pkg
// Shared types, constants and key compare function for the ordered map.
// ----------------------------------------------------------------------------
package okvm_pkg;

    // Default sizes of the map.
    localparam int DEF_CAPACITY          = 16;
    localparam int DEF_VALUE_BITS        = 32;
    localparam int DEF_STRING_INDEX_BITS = 16;

    // Fixed port widths of the word fields.
    localparam int KEY_NUM_BITS     = 32;
    localparam int VALUE_PORT_BITS  = 32;
    localparam int STRING_PORT_BITS = 16;
    localparam int COUNT_PORT_BITS  = 5;

    // Operation codes.
    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_SET    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic cap_match;  // register the compare result of this cell
        logic set_hit;    // overwrite the value of the matching cell
        logic append;     // load the new entry into the first free cell
        logic del;        // cells at or above the hit take their neighbor
    } cell_cmd_t;

    // True when the single-precision pattern is a NaN.
    function automatic logic is_nan32(input logic [KEY_NUM_BITS-1:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // SameValueZero: all NaNs are equal, and +0 equals -0.
    function automatic logic same_value_zero(input logic [KEY_NUM_BITS-1:0] a,
                                             input logic [KEY_NUM_BITS-1:0] b);
        logic na;
        logic nb;
        na = is_nan32(a);
        nb = is_nan32(b);
        if (na || nb) begin
            return na && nb;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return 1'b1;
        end
        return a == b;
    endfunction

endpackage

/* design/okvm_cell.sv */
// ----------------------------------------------------------------------------
// okvm_cell
// One slot of the map: holds a key and value, compares against the broadcast
// key, and on a delete at or below its index takes the entry of its upper neighbor.
// ----------------------------------------------------------------------------
module okvm_cell
    import okvm_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int INDEX    = 0,
    parameter int VAL_W    = DEF_VALUE_BITS,
    parameter int STR_W    = DEF_STRING_INDEX_BITS
) (
    input  logic                    aclk,
    input  cell_cmd_t               cmd_i,
    input  logic [$clog2(CAPACITY+1)-1:0] count_i,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx_i,
    // broadcast operation key and value
    input  logic                    key_is_num_i,
    input  logic [KEY_NUM_BITS-1:0] key_num_i,
    input  logic [STR_W-1:0]        key_str_i,
    input  logic [VAL_W-1:0]        new_val_i,
    // entry of the upper neighbor
    input  logic                    nb_is_num_i,
    input  logic [KEY_NUM_BITS-1:0] nb_num_i,
    input  logic [STR_W-1:0]        nb_str_i,
    input  logic [VAL_W-1:0]        nb_val_i,
    // own entry and compare result
    output logic                    is_num_o,
    output logic [KEY_NUM_BITS-1:0] num_o,
    output logic [STR_W-1:0]        str_o,
    output logic [VAL_W-1:0]        val_o,
    output logic                    match_o
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                    is_num_reg;
    logic [KEY_NUM_BITS-1:0] num_reg;
    logic [STR_W-1:0]        str_reg;
    logic [VAL_W-1:0]        val_reg;
    logic                    match_reg;
    logic                    live;
    logic                    key_eq;
    logic                    match_next;

    // A slot only takes part while it lies below the live count.
    always_comb begin
        live = CW'(INDEX) < count_i;
        if (key_is_num_i) begin
            key_eq = is_num_reg && same_value_zero(num_reg, key_num_i);
        end else begin
            key_eq = !is_num_reg && (str_reg == key_str_i);
        end
        match_next = live && key_eq;
    end

    // Compare result is held for the update cycle.
    always_ff @(posedge aclk) begin
        if (cmd_i.cap_match) begin
            match_reg <= match_next;
        end
    end

    // Entry storage: append, overwrite, or shift down from the neighbor.
    always_ff @(posedge aclk) begin
        if (cmd_i.append && (count_i == CW'(INDEX))) begin
            is_num_reg <= key_is_num_i;
            num_reg    <= key_num_i;
            str_reg    <= key_str_i;
            val_reg    <= new_val_i;
        end else if (cmd_i.set_hit && match_reg) begin
            val_reg <= new_val_i;
        end else if (cmd_i.del && (IW'(INDEX) >= hit_idx_i)) begin
            is_num_reg <= nb_is_num_i;
            num_reg    <= nb_num_i;
            str_reg    <= nb_str_i;
            val_reg    <= nb_val_i;
        end
    end

    assign is_num_o = is_num_reg;
    assign num_o    = num_reg;
    assign str_o    = str_reg;
    assign val_o    = val_reg;
    assign match_o  = match_reg;

endmodule

/* design/ordered_key_value_map.sv */
// The result word is registered after the compare state and the update state of
// the cell chain; a waiting result word delays the update state. A new operation
// word is accepted only while idle or during the update of the previous one.
// Reset: the live count, the sequencer and the output valid are cleared; slot
// contents stay undefined and are never read before being written, so there is
// no clearing pass.
// ----------------------------------------------------------------------------
// ordered_key_value_map
// Fixed-capacity ordered key-value map built as a chain of slot cells with
// lookup, set and delete on number or string keys.
// ----------------------------------------------------------------------------
`include "ordered_key_value_map_assert.svh"

module ordered_key_value_map
    import okvm_pkg::*;
#(
    parameter int CAPACITY          = DEF_CAPACITY,
    parameter int VALUE_BITS        = DEF_VALUE_BITS,
    parameter int STRING_INDEX_BITS = DEF_STRING_INDEX_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // operation words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic                        s_key_is_number,
    input  logic [KEY_NUM_BITS-1:0]     s_key_number,
    input  logic [STRING_PORT_BITS-1:0] s_key_string_index,
    input  logic [VALUE_PORT_BITS-1:0]  s_new_value,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic [VALUE_PORT_BITS-1:0]  m_value_out,
    output logic                        m_status,
    output logic [COUNT_PORT_BITS-1:0]  m_entry_count
);

    // Stored widths never exceed the port widths.
    localparam int VW = (VALUE_BITS < VALUE_PORT_BITS) ? VALUE_BITS : VALUE_PORT_BITS;
    localparam int SW = (STRING_INDEX_BITS < STRING_PORT_BITS) ?
                        STRING_INDEX_BITS : STRING_PORT_BITS;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_APPLY
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    mode_t                   mode_reg;
    logic                    is_num_reg;
    logic [KEY_NUM_BITS-1:0] num_reg;
    logic [SW-1:0]           str_reg;
    logic [VW-1:0]           val_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;

    logic                       m_valid_reg;
    logic                       m_found_reg;
    logic [VALUE_PORT_BITS-1:0] m_value_reg;
    logic                       m_status_reg;
    logic [COUNT_PORT_BITS-1:0] m_count_reg;

    logic                    accept;
    logic                    out_free;
    logic                    apply_go;
    logic                    found;
    logic                    full;
    logic                    do_append;
    logic                    do_delete;
    logic                    status;
    logic [IW-1:0]           hit_idx;
    logic [VW-1:0]           rd_val;
    logic [CAPACITY-1:0]     match_vec;
    cell_cmd_t               cmd;

    logic                    cell_is_num [CAPACITY];
    logic [KEY_NUM_BITS-1:0] cell_num    [CAPACITY];
    logic [SW-1:0]           cell_str    [CAPACITY];
    logic [VW-1:0]           cell_val    [CAPACITY];

    // Handshake: a new word enters when idle or while the last one retires.
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        apply_go = (state_reg == ST_APPLY) && out_free;
        s_ready  = (state_reg == ST_IDLE) || apply_go;
        accept   = s_valid && s_ready;
    end

    // Hit decode over the registered compare results of the cells.
    always_comb begin
        hit_idx = '0;
        rd_val  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (match_vec[i]) begin
                hit_idx = hit_idx | IW'(i);
                rd_val  = rd_val | cell_val[i];
            end
        end
        found     = (mode_reg != MODE_NOP) && (|match_vec);
        full      = count_reg == CW'(CAPACITY);
        do_append = (mode_reg == MODE_SET) && !found && !full;
        do_delete = (mode_reg == MODE_DELETE) && found;
        status    = (mode_reg == MODE_SET) && !found && full;
    end

    // Commands to the cell chain.
    always_comb begin
        cmd.cap_match = state_reg == ST_MATCH;
        cmd.set_hit   = apply_go && (mode_reg == MODE_SET) && found;
        cmd.append    = apply_go && do_append;
        cmd.del       = apply_go && do_delete;
    end

    // Next state and live count.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                if (apply_go) begin
                    state_next = accept ? ST_MATCH : ST_IDLE;
                    if (do_append) begin
                        count_next = count_reg + CW'(1);
                    end else if (do_delete) begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (apply_go) begin
            m_found_reg  <= found;
            m_value_reg  <= ((mode_reg == MODE_LOOKUP) && found) ?
                            VALUE_PORT_BITS'(rd_val) : '0;
            m_status_reg <= status;
            m_count_reg  <= COUNT_PORT_BITS'(count_next);
        end
    end

    // Operation word capture.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg   <= mode_t'(s_mode);
            is_num_reg <= s_key_is_number;
            num_reg    <= s_key_number;
            str_reg    <= s_key_string_index[SW-1:0];
            val_reg    <= s_new_value[VW-1:0];
        end
    end

    // Chain of slot cells; the top cell takes its own entry on a shift.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    nb_is_num;
        logic [KEY_NUM_BITS-1:0] nb_num;
        logic [SW-1:0]           nb_str;
        logic [VW-1:0]           nb_val;

        if (g == CAPACITY - 1) begin : g_top
            assign nb_is_num = cell_is_num[g];
            assign nb_num    = cell_num[g];
            assign nb_str    = cell_str[g];
            assign nb_val    = cell_val[g];
        end else begin : g_mid
            assign nb_is_num = cell_is_num[g+1];
            assign nb_num    = cell_num[g+1];
            assign nb_str    = cell_str[g+1];
            assign nb_val    = cell_val[g+1];
        end

        okvm_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g),
            .VAL_W    (VW),
            .STR_W    (SW)
        ) u_cell (
            .aclk         (aclk),
            .cmd_i        (cmd),
            .count_i      (count_reg),
            .hit_idx_i    (hit_idx),
            .key_is_num_i (is_num_reg),
            .key_num_i    (num_reg),
            .key_str_i    (str_reg),
            .new_val_i    (val_reg),
            .nb_is_num_i  (nb_is_num),
            .nb_num_i     (nb_num),
            .nb_str_i     (nb_str),
            .nb_val_i     (nb_val),
            .is_num_o     (cell_is_num[g]),
            .num_o        (cell_num[g]),
            .str_o        (cell_str[g]),
            .val_o        (cell_val[g]),
            .match_o      (match_vec[g])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_value_out   = m_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

    // Keys are unique, so at most one cell may match.
    `OKVM_ASSERT(a_single_hit, aclk, aresetn, (state_reg == ST_APPLY) |-> $onehot0(match_vec))
    // The live count never passes the capacity once reset is released.
    `OKVM_ASSERT_ALWAYS(a_count_range, aclk, !aresetn || (count_reg <= CW'(CAPACITY)))
    // A full status only comes from a miss on a full table.
    `OKVM_ASSERT(a_full_status, aclk, aresetn, (m_valid_reg && m_status_reg) |-> (!m_found_reg && (count_reg == CW'(CAPACITY))))
    // A successful delete removes exactly one entry.
    `OKVM_ASSERT(a_delete_count, aclk, aresetn, (apply_go && do_delete) |=> (count_reg == $past(count_reg) - CW'(1)))

endmodule
